[rtl/cvsc_pkg.sv]
// ----------------------------------------------------------------------------
// cvsc_pkg
// Shared types, codes and protocol constants for the vehicle-side DC charge
// controller.
// ----------------------------------------------------------------------------
package cvsc_pkg;

    // item modes
    typedef enum logic [2:0] {
        MODE_RX_108  = 3'd0,
        MODE_RX_109  = 3'd1,
        MODE_SET_CUR = 3'd2,
        MODE_CHECK   = 3'd3,
        MODE_TICK    = 3'd4,
        MODE_SEND    = 3'd5,
        MODE_ENABLE  = 3'd6
    } t_mode;

    // result kinds
    localparam logic KIND_TIMEOUT = 1'b0;
    localparam logic KIND_FRAME   = 1'b1;

    // configuration register indexes (paddr[2])
    localparam logic REG_TARGET_VOLT = 1'b0;
    localparam logic REG_PROTO_VER   = 1'b1;
    localparam int   APB_ADDR_W      = 3;

    localparam logic [3:0]  LINK_RELOAD       = 4'd10;
    localparam logic [8:0]  CUR_MARGIN        = 9'd12;
    localparam logic [15:0] VTG_MARGIN        = 16'd10;
    localparam logic [7:0]  CUR_FAULT_LIMIT   = 8'd10;
    localparam logic [7:0]  VTG_FAULT_LIMIT   = 8'd50;
    localparam logic [5:0]  STATUS_MASK       = 6'h3F;
    localparam logic [7:0]  CAPACITY_CODE     = 8'd200;
    localparam logic [15:0] TARGET_OFFSET     = 16'd40;
    localparam logic [31:0] CHARGE_TIME_WORD  = 32'h00FE_FF00;
    localparam logic [10:0] ID_FRAME_A        = 11'h100;
    localparam logic [10:0] ID_FRAME_B        = 11'h101;
    localparam logic [10:0] ID_FRAME_C        = 11'h102;
    localparam logic [7:0]  CONVERTER_VERSION = 8'd10;
    localparam logic [7:0]  COUNT_MAX         = 8'd255;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] rx_word_low;
        logic [31:0] rx_word_high;
        logic [7:0]  current_request;
        logic [15:0] internal_voltage;
        logic        enable_flag;
        logic [15:0] battery_voltage;
        logic [7:0]  state_of_charge;
        logic        parking_flag;
        logic        vehicle_fault;
        logic        contactor_open;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [10:0] frame_id;
        logic [31:0] tx_word_low;
        logic [31:0] tx_word_high;
        logic        link_timed_out;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] target_battery_voltage;
        logic [7:0]  protocol_version;
    } t_cfg;

    // results of one item; item[0] goes out first
    typedef struct packed {
        logic [1:0]             nres;
        t_out_item [2:0]        item;
    } t_res_grp;

endpackage

[rtl/cvsc_apb.sv]
// ----------------------------------------------------------------------------
// cvsc_apb
// APB register file: target battery voltage and protocol version.
// ----------------------------------------------------------------------------
module cvsc_apb (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cvsc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output cvsc_pkg::t_cfg                    o_cfg
);

    cvsc_pkg::t_cfg r_cfg;
    cvsc_pkg::t_cfg n_cfg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (paddr[2])
                cvsc_pkg::REG_TARGET_VOLT: n_cfg.target_battery_voltage = pwdata[15:0];
                cvsc_pkg::REG_PROTO_VER:   n_cfg.protocol_version       = pwdata[7:0];
                default:                   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_battery_voltage <= 16'd0;
            r_cfg.protocol_version       <= 8'd1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (paddr[2])
            cvsc_pkg::REG_TARGET_VOLT: prdata = {16'd0, r_cfg.target_battery_voltage};
            cvsc_pkg::REG_PROTO_VER:   prdata = {24'd0, r_cfg.protocol_version};
            default:                   prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/cvsc_core.sv]
// ----------------------------------------------------------------------------
// cvsc_core
// Protocol state and the single-pass update/result logic for one item.
// ----------------------------------------------------------------------------
module cvsc_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  cvsc_pkg::t_in_item   i_item,
    input  cvsc_pkg::t_cfg       i_cfg,
    output cvsc_pkg::t_res_grp   o_res
);

    logic [7:0]  r_max_cur,  n_max_cur;
    logic [7:0]  r_ver,      n_ver;
    logic [15:0] r_out_volt, n_out_volt;
    logic [7:0]  r_out_cur,  n_out_cur;
    logic [5:0]  r_status,   n_status;
    logic        r_enabled,  n_enabled;
    logic [7:0]  r_ramp,     n_ramp;
    logic [7:0]  r_vcnt,     n_vcnt;
    logic [7:0]  r_ccnt,     n_ccnt;
    logic [3:0]  r_link,     n_link;

    logic [7:0]  goal;
    logic [15:0] dev;
    logic        charging;
    logic        cur_fault;
    logic        vtg_fault;

    always_comb begin
        goal      = (i_item.current_request < r_max_cur) ? i_item.current_request : r_max_cur;
        dev       = (i_item.internal_voltage >= r_out_volt) ?
                    i_item.internal_voltage - r_out_volt : r_out_volt - i_item.internal_voltage;
        charging  = r_status[0];
        cur_fault = r_ccnt > cvsc_pkg::CUR_FAULT_LIMIT;
        vtg_fault = r_vcnt > cvsc_pkg::VTG_FAULT_LIMIT;

        n_max_cur  = r_max_cur;
        n_ver      = r_ver;
        n_out_volt = r_out_volt;
        n_out_cur  = r_out_cur;
        n_status   = r_status;
        n_enabled  = r_enabled;
        n_ramp     = r_ramp;
        n_vcnt     = r_vcnt;
        n_ccnt     = r_ccnt;
        n_link     = r_link;
        o_res      = '0;

        unique case (i_item.mode)
            cvsc_pkg::MODE_RX_108: begin
                n_max_cur = i_item.rx_word_low[31:24];
                n_link    = cvsc_pkg::LINK_RELOAD;
            end
            cvsc_pkg::MODE_RX_109: begin
                n_ver      = i_item.rx_word_low[7:0];
                n_out_volt = i_item.rx_word_low[23:8];
                n_out_cur  = i_item.rx_word_low[31:24];
                n_status   = i_item.rx_word_high[13:8] & cvsc_pkg::STATUS_MASK;
                n_link     = cvsc_pkg::LINK_RELOAD;
            end
            cvsc_pkg::MODE_SET_CUR: begin
                if (goal > r_ramp) begin
                    n_ramp = r_ramp + 8'd1;
                end else if (goal < r_ramp) begin
                    n_ramp = r_ramp - 8'd1;
                end
            end
            cvsc_pkg::MODE_CHECK: begin
                if (charging && dev > cvsc_pkg::VTG_MARGIN) begin
                    n_vcnt = (r_vcnt == cvsc_pkg::COUNT_MAX) ? r_vcnt : r_vcnt + 8'd1;
                end else begin
                    n_vcnt = 8'd0;
                end
                if (charging && {1'b0, r_out_cur} > {1'b0, r_ramp} + cvsc_pkg::CUR_MARGIN) begin
                    n_ccnt = (r_ccnt == cvsc_pkg::COUNT_MAX) ? r_ccnt : r_ccnt + 8'd1;
                end else begin
                    n_ccnt = 8'd0;
                end
            end
            cvsc_pkg::MODE_TICK: begin
                if (r_link != 4'd0) begin
                    n_link = r_link - 4'd1;
                end
                o_res.nres                   = 2'd1;
                o_res.item[0].result_kind    = cvsc_pkg::KIND_TIMEOUT;
                o_res.item[0].link_timed_out = (r_link <= 4'd1);
                o_res.item[0].last           = 1'b1;
            end
            cvsc_pkg::MODE_SEND: begin
                o_res.nres = 2'd3;

                o_res.item[0].result_kind  = cvsc_pkg::KIND_FRAME;
                o_res.item[0].frame_id     = cvsc_pkg::ID_FRAME_A;
                o_res.item[0].tx_word_low  = (r_ver == cvsc_pkg::CONVERTER_VERSION) ?
                                             {16'd0, i_item.battery_voltage} : 32'd0;
                o_res.item[0].tx_word_high = {8'd0, cvsc_pkg::CAPACITY_CODE,
                    i_cfg.target_battery_voltage + cvsc_pkg::TARGET_OFFSET};

                o_res.item[1].result_kind  = cvsc_pkg::KIND_FRAME;
                o_res.item[1].frame_id     = cvsc_pkg::ID_FRAME_B;
                o_res.item[1].tx_word_low  = cvsc_pkg::CHARGE_TIME_WORD;

                o_res.item[2].result_kind  = cvsc_pkg::KIND_FRAME;
                o_res.item[2].frame_id     = cvsc_pkg::ID_FRAME_C;
                o_res.item[2].tx_word_low  = {r_ramp, i_cfg.target_battery_voltage,
                                              i_cfg.protocol_version};
                o_res.item[2].tx_word_high = {8'd0, i_item.state_of_charge, 4'd0,
                    i_item.contactor_open, i_item.vehicle_fault, i_item.parking_flag,
                    r_enabled, 3'd0, vtg_fault, 1'b0, cur_fault, 2'd0};
                o_res.item[2].last         = 1'b1;
            end
            cvsc_pkg::MODE_ENABLE: begin
                n_enabled = i_item.enable_flag;
                if (!i_item.enable_flag) begin
                    n_ramp = 8'd0;
                    n_vcnt = 8'd0;
                    n_ccnt = 8'd0;
                end
            end
            default: ; // reserved mode: no effect
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_cur  <= 8'd0;
            r_ver      <= 8'd1;
            r_out_volt <= 16'd0;
            r_out_cur  <= 8'd0;
            r_status   <= 6'd0;
            r_enabled  <= 1'b0;
            r_ramp     <= 8'd0;
            r_vcnt     <= 8'd0;
            r_ccnt     <= 8'd0;
            r_link     <= 4'd0;
        end else if (i_go) begin
            r_max_cur  <= n_max_cur;
            r_ver      <= n_ver;
            r_out_volt <= n_out_volt;
            r_out_cur  <= n_out_cur;
            r_status   <= n_status;
            r_enabled  <= n_enabled;
            r_ramp     <= n_ramp;
            r_vcnt     <= n_vcnt;
            r_ccnt     <= n_ccnt;
            r_link     <= n_link;
        end
    end

endmodule

[rtl/cvsc_txq.sv]
// ----------------------------------------------------------------------------
// cvsc_txq
// Result register: holds up to three result beats and shifts them out.
// ----------------------------------------------------------------------------
module cvsc_txq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  cvsc_pkg::t_res_grp   i_res,
    output logic                 o_free,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output cvsc_pkg::t_out_item  o_out_item
);

    cvsc_pkg::t_out_item [2:0] r_q, n_q;
    logic [1:0]                r_cnt, n_cnt;
    logic                      take;

    assign o_out_valid = (r_cnt != 2'd0);
    assign take        = o_out_valid && i_out_ready;
    assign o_free      = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && take);
    assign o_out_item  = r_q[0];

    always_comb begin
        n_q   = r_q;
        n_cnt = r_cnt;
        if (i_load && (i_res.nres != 2'd0)) begin
            n_q   = i_res.item;
            n_cnt = i_res.nres;
        end else if (take) begin
            n_q[0] = r_q[1];
            n_q[1] = r_q[2];
            n_cnt  = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

endmodule

[rtl/dc_charge_vehicle_side_controller.sv]
// ----------------------------------------------------------------------------
// dc_charge_vehicle_side_controller
// Vehicle side of a DC fast-charge CAN exchange: decodes charger frames,
// ramps the current request, tracks deviations and builds vehicle frames.
// ----------------------------------------------------------------------------
// Each input beat is latched in an input register and handled in a single
// pass by the core, which updates the protocol state and builds its results
// at once. Beats that cause no result (modes 0-3, 6 and the reserved mode 7)
// go at one per cycle. A tick yields one timeout-report beat and a send
// yields three frame beats (0x100, 0x101, 0x102, last flag on the third);
// they sit in a three-deep result register and leave one per cycle over
// the single output channel while the output is ready, so a send holds
// that register until its final beat is handed over. A beat that makes
// results is handled only once the result register is empty or handing
// over its final beat, and the input stays closed while it waits; quiet
// beats that follow a group already in the result register keep flowing.
// An accepted beat passes the input register, then the result register.
// Configuration sits on an APB port: 0x0 target battery voltage (16 bit),
// 0x4 protocol version (8 bit); address bits [1:0] are ignored.
// ----------------------------------------------------------------------------
module dc_charge_vehicle_side_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input item channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  cvsc_pkg::t_in_item                i_in_item,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output cvsc_pkg::t_out_item               o_out_item,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cvsc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic                r_in_valid, n_in_valid;
    cvsc_pkg::t_in_item  r_in_item,  n_in_item;
    cvsc_pkg::t_cfg      cfg;
    cvsc_pkg::t_res_grp  res;
    logic                q_free;
    logic                go;

    cvsc_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Item in the input register is handled now unless its results would
    // land on a result register that is still busy.
    assign go         = r_in_valid && ((res.nres == 2'd0) || q_free);
    assign o_in_ready = !r_in_valid || go;

    always_comb begin
        n_in_valid = r_in_valid;
        n_in_item  = r_in_item;
        if (i_in_valid && o_in_ready) begin
            n_in_valid = 1'b1;
            n_in_item  = i_in_item;
        end else if (go) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_item <= n_in_item;
    end

    cvsc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_item  (r_in_item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    cvsc_txq u_txq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (go),
        .i_res       (res),
        .o_free      (q_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

[rtl/cvsc_checker.sv]
// ----------------------------------------------------------------------------
// cvsc_checker
// Port-level checks on the controller, bound to the top level.
// ----------------------------------------------------------------------------
module cvsc_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 o_in_ready,
    input  logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  cvsc_pkg::t_out_item  o_out_item
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result beat changed while stalled");

    // send frames leave back to back: 0x100 then 0x101
    a_frame_b_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_item.frame_id == cvsc_pkg::ID_FRAME_A
        |=> o_out_valid && o_out_item.frame_id == cvsc_pkg::ID_FRAME_B
            && !o_out_item.last)
        else $error("frame 0x101 did not follow 0x100");

    // 0x101 then 0x102 closing the send
    a_frame_c_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_item.frame_id == cvsc_pkg::ID_FRAME_B
        |=> o_out_valid && o_out_item.frame_id == cvsc_pkg::ID_FRAME_C
            && o_out_item.last)
        else $error("frame 0x102 did not follow 0x101");

    // with nothing waiting on the output, the input side must be open
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

endmodule

bind dc_charge_vehicle_side_controller cvsc_checker u_cvsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
